FILE: src/ltma_pkg.sv
`timescale 1ns / 1ps

package ltma_pkg;

   // field and register widths
   localparam int DATA_W    = 16;
   localparam int CSR_IDX_W = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEED   = 4'd1;

   // configuration reset values
   localparam logic [DATA_W-1:0] JUMP_LIMIT_RESET = 16'd800;
   localparam logic [DATA_W-1:0] MIN_SEED_RESET   = 16'd16000;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIM,
      ST_DIV,
      ST_DONE
   } state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: src/ltma_cell.sv
`timescale 1ns / 1ps

module ltma_cell
   import ltma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic [DATA_W-1:0] data_in,
   output logic [DATA_W-1:0] data_out
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in_w;

   // hold the entry, or take the neighbor's one
   assign data_in_w = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in_w;
      end
   end

   assign data_out = data_ff;

endmodule

FILE: src/ltma_scan.sv
`timescale 1ns / 1ps

module ltma_scan
   import ltma_pkg::*;
#(
   parameter int WINDOW = 10
)
(
   input  logic                                 clock,
   input  logic                                 clear,
   input  logic                                 step,
   input  logic [DATA_W-1:0]                    seed,
   input  logic [DATA_W-1:0]                    value,
   output logic [DATA_W+$clog2(WINDOW)-1:0]     sum,
   output logic [DATA_W-1:0]                    max_val,
   output logic [DATA_W-1:0]                    min_val
);

   localparam int SUM_W = DATA_W + $clog2(WINDOW);

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DATA_W-1:0] max_ff, max_in;
   logic [DATA_W-1:0] min_ff, min_in;

   always_comb begin
      sum_in = sum_ff;
      max_in = max_ff;
      min_in = min_ff;
      if (clear) begin
         sum_in = '0;
         max_in = '0;
         min_in = seed;
      end else if (step) begin
         sum_in = sum_ff + SUM_W'(value);
         if (value > max_ff) begin
            max_in = value;
         end
         if (value < min_ff) begin
            min_in = value;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      max_ff <= max_in;
      min_ff <= min_in;
   end

   assign sum     = sum_ff;
   assign max_val = max_ff;
   assign min_val = min_ff;

endmodule

FILE: src/ltma_div.sv
`timescale 1ns / 1ps

module ltma_div
   import ltma_pkg::*;
#(
   parameter int WINDOW = 10
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DATA_W+$clog2(WINDOW):0]      dividend,
   output div_status_type                      status,
   output logic [DATA_W-1:0]                   quotient
);

   localparam int SUM_W  = DATA_W + $clog2(WINDOW);
   localparam int DIV_W  = $clog2(WINDOW - 1);
   localparam int T_W    = DIV_W + 2;
   localparam int STEPS  = DATA_W / 2;
   localparam int CNT_W  = $clog2(STEPS);
   localparam logic [SUM_W-1:0] D_SUM = SUM_W'(WINDOW - 2);
   localparam logic [T_W-1:0]   D1    = T_W'(WINDOW - 2);
   localparam logic [T_W-1:0]   D2    = T_W'(2 * (WINDOW - 2));
   localparam logic [T_W-1:0]   D3    = T_W'(3 * (WINDOW - 2));
   localparam logic [CNT_W-1:0] LAST  = CNT_W'(STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              sat_ff, sat_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [T_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] quo_ff, quo_in;

   logic [SUM_W-1:0]  top_ext;
   logic [T_W-1:0]    trial;
   logic [1:0]        digit;
   logic [T_W-1:0]    rem_next;

   assign top_ext = SUM_W'(dividend[SUM_W-1:DATA_W]);

   // radix-4 digit: partial remainder times four plus the next two bits
   always_comb begin
      trial = {rem_ff[T_W-3:0], low_ff[DATA_W-1:DATA_W-2]};
      if (trial >= D3) begin
         digit    = 2'd3;
         rem_next = trial - D3;
      end else if (trial >= D2) begin
         digit    = 2'd2;
         rem_next = trial - D2;
      end else if (trial >= D1) begin
         digit    = 2'd1;
         rem_next = trial - D1;
      end else begin
         digit    = 2'd0;
         rem_next = trial;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = dividend[SUM_W];
         // upper part at or above the divisor means a quotient past 16 bits
         sat_in  = top_ext >= D_SUM;
         cnt_in  = '0;
         rem_in  = T_W'(dividend[SUM_W-1:DATA_W]);
         low_in  = dividend[DATA_W-1:0];
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_next;
         low_in = {low_ff[DATA_W-3:0], 2'b00};
         quo_in = {quo_ff[DATA_W-3:0], digit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff <= sat_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      if (neg_ff) begin
         quotient = '0;
      end else if (sat_ff) begin
         quotient = '1;
      end else begin
         quotient = quo_ff;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/limit_then_trimmed_moving_average_unit.sv
`timescale 1ns / 1ps

// Spike-limited, trimmed moving-average filter for distance samples in 1/16 cm
// units. Each sample is first checked against the last accepted value: a jump
// larger than the jump limit register is replaced by that last value (any sample
// is accepted while the last value is zero). The chosen value enters a window of
// WINDOW entries held in a row of shift cells. The window is then rotated once
// around the row, one cell per cycle, while a scan unit collects the sum, maximum
// (starting at 0) and minimum (starting at min_seed). Sum minus maximum minus
// minimum is divided by WINDOW-2 in a radix-4 divider, two quotient bits a
// cycle, and saturated to 0..65535. From its transfer on req to its result in
// the output register, an item passes the rotation of the cell row and then
// the eight divider steps; a new sample is taken only once the previous one
// has left the divider. A finished result waits in the output register while
// the next sample is taken. Configuration writes on csr are taken at any time
// and must be issued only while the unit is idle.
module limit_then_trimmed_moving_average_unit
   import ltma_pkg::*;
#(
   parameter int WINDOW = 10
)
(
   input  logic                 clock,
   input  logic                 reset,
   // sample input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [15:0] sample
   // filtered output
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [15:0] filtered
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   localparam int SUM_W = DATA_W + $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW - 1);

   // configuration registers
   logic [DATA_W-1:0] jump_limit_ff, jump_limit_in;
   logic [DATA_W-1:0] min_seed_ff, min_seed_in;

   // spike limiter
   logic [DATA_W-1:0] last_ff, last_in;
   logic [DATA_W-1:0] jump;
   logic [DATA_W-1:0] chosen;

   // sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             req_xfer;
   logic             shift_en;
   logic             scan_clear;
   logic             scan_step;
   logic             div_start;
   logic             load_out;

   // cell row
   logic [DATA_W-1:0] cell_q [WINDOW];
   logic [DATA_W-1:0] row_in;

   // scan and divide
   logic [SUM_W-1:0]  scan_sum;
   logic [DATA_W-1:0] scan_max;
   logic [DATA_W-1:0] scan_min;
   logic [SUM_W:0]    trimmed;
   div_status_type    div_status;
   logic [DATA_W-1:0] div_quo;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;

   //------------------------------------------------------------------
   // configuration writes, unknown indexes are dropped
   //------------------------------------------------------------------
   always_comb begin
      jump_limit_in = jump_limit_ff;
      min_seed_in   = min_seed_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_JUMP_LIMIT: jump_limit_in = csr_data;
            CSR_MIN_SEED:   min_seed_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff <= JUMP_LIMIT_RESET;
         min_seed_ff   <= MIN_SEED_RESET;
      end else begin
         jump_limit_ff <= jump_limit_in;
         min_seed_ff   <= min_seed_in;
      end
   end

   //------------------------------------------------------------------
   // spike limiter: a jump equal to the limit still passes
   //------------------------------------------------------------------
   assign jump = (req_tdata >= last_ff) ? (req_tdata - last_ff) : (last_ff - req_tdata);

   always_comb begin
      chosen  = req_tdata;
      last_in = last_ff;
      if (req_xfer) begin
         if (last_ff != '0 && jump > jump_limit_ff) begin
            chosen = last_ff;
         end else begin
            last_in = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   //------------------------------------------------------------------
   // sequencer
   //------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_xfer) begin
            state_in = ST_SCAN;
         end
         ST_SCAN: if (scan_cnt_ff == SCAN_LAST) begin
            state_in = ST_TRIM;
         end
         ST_TRIM: state_in = ST_DIV;
         ST_DIV: if (div_status.done) begin
            state_in = ST_DONE;
         end
         ST_DONE: if (!rsp_valid_ff || rsp_tready) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      scan_clear  = 1'b0;
      scan_step   = 1'b0;
      div_start   = 1'b0;
      load_out    = 1'b0;
      scan_cnt_in = scan_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            scan_clear  = req_xfer;
            scan_cnt_in = '0;
         end
         ST_SCAN: begin
            scan_step   = 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
         ST_TRIM: div_start = 1'b1;
         ST_DIV: ;
         ST_DONE: load_out = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   //------------------------------------------------------------------
   // cell row: new entry shifts in on a transfer, then the row rotates
   // once so every entry passes the tail exactly once
   //------------------------------------------------------------------
   assign shift_en = req_xfer || scan_step;
   assign row_in   = (state_ff == ST_IDLE) ? chosen : cell_q[WINDOW-1];

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      ltma_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .data_in  ((k == 0) ? row_in : cell_q[(k == 0) ? 0 : k-1]),
         .data_out (cell_q[k])
      );
   end

   ltma_scan #(
      .WINDOW (WINDOW)
   ) u_scan (
      .clock   (clock),
      .clear   (scan_clear),
      .step    (scan_step),
      .seed    (min_seed_ff),
      .value   (cell_q[WINDOW-1]),
      .sum     (scan_sum),
      .max_val (scan_max),
      .min_val (scan_min)
   );

   // trimmed sum, top bit set when it went below zero
   assign trimmed = {1'b0, scan_sum} - (SUM_W+1)'(scan_max) - (SUM_W+1)'(scan_min);

   ltma_div #(
      .WINDOW (WINDOW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (trimmed),
      .status   (div_status),
      .quotient (div_quo)
   );

   //------------------------------------------------------------------
   // output register
   //------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   //------------------------------------------------------------------
   // checks
   //------------------------------------------------------------------
   // a sample transfer always starts a rotation of the cell row
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_SCAN)
      else $error("sample transfer did not start the window scan");

   // the divider never runs while the row is being scanned
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !div_status.busy)
      else $error("divider busy during window scan");

   // a finished quotient moves on to the output stage
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_status.done) |=> state_ff == ST_DONE)
      else $error("divider result not picked up");

   // a new result appears only when loaded from the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result appeared outside the done state");

endmodule
